FILE: sv/ad_census_match_cost_defines.svh
// Assertion macros for the AD-Census matching cost block.
// Used by the top level; relies on clk_i and rst_ni in the including module.
`ifndef AD_CENSUS_MATCH_COST_DEFINES_SVH
`define AD_CENSUS_MATCH_COST_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define ACMC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define ACMC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/acmc_pkg.sv
// Shared types, constants and the divide-by-k reciprocal table for the
// AD-Census matching cost block. No dependencies.
package acmc_pkg;

  localparam int unsigned SCALE_W = 20;
  localparam int unsigned CNT_W   = 12;
  localparam int unsigned SAD_W   = 10;
  localparam int unsigned COST_W  = 16;
  localparam int unsigned PIX_W   = 24;
  localparam int unsigned IDX_W   = 2;

  localparam logic [SCALE_W-1:0] SCALE_RST = 20'd2185;
  localparam logic [CNT_W-1:0]   COUNT_MAX = 12'hFFF;

  // register indexes on the configuration channel
  localparam logic [IDX_W-1:0] REG_AD_SCALE     = 2'd0;
  localparam logic [IDX_W-1:0] REG_CENSUS_SCALE = 2'd1;

  localparam logic [30:0] ONE_Q30    = 31'h4000_0000;
  localparam logic [3:0]  K_LAST     = 4'd12;  // Taylor terms
  localparam logic [2:0]  SQ_LAST    = 3'd4;   // five squarings, 0..4

  typedef struct packed {
    logic [SAD_W-1:0] abs_diff_sum;
    logic [CNT_W-1:0] census_total;
  } win_res_t;

  typedef struct packed {
    logic [SAD_W-1:0]  abs_diff_sum;
    logic [CNT_W-1:0]  census_total;
    logic [COST_W-1:0] match_cost;
  } cost_res_t;

  typedef struct packed {
    logic start;     // last item of a window accepted
    logic out_free;  // output register can take a result this cycle
  } cost_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } cost_sts_t;

  // floor(2^32/k); k = 1 uses 2^32-1, corrected by the remainder check
  function automatic logic [31:0] recip_k(input logic [3:0] k);
    logic [31:0] r;
    unique case (k)
      4'd2:    r = 32'h8000_0000;
      4'd3:    r = 32'h5555_5555;
      4'd4:    r = 32'h4000_0000;
      4'd5:    r = 32'h3333_3333;
      4'd6:    r = 32'h2AAA_AAAA;
      4'd7:    r = 32'h2492_4924;
      4'd8:    r = 32'h2000_0000;
      4'd9:    r = 32'h1C71_C71C;
      4'd10:   r = 32'h1999_9999;
      4'd11:   r = 32'h1745_D174;
      4'd12:   r = 32'h1555_5555;
      default: r = 32'hFFFF_FFFF;
    endcase
    return r;
  endfunction

endpackage

FILE: sv/acmc_census.sv
// Census window accumulator: per-item opposite-sign channel count with
// saturation, plus SAD of the reference pixels. Depends on acmc_pkg.
module acmc_census (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             accept_i,
  input  logic                             last_i,
  input  logic [acmc_pkg::PIX_W-1:0]       ref_left_rgb_i,
  input  logic [acmc_pkg::PIX_W-1:0]       ref_right_rgb_i,
  input  logic [acmc_pkg::PIX_W-1:0]       win_left_rgb_i,
  input  logic [acmc_pkg::PIX_W-1:0]       win_right_rgb_i,
  output acmc_pkg::win_res_t               res_o
);
  import acmc_pkg::*;

  logic [CNT_W-1:0] count_q, count_d;
  logic [1:0]       hits;
  logic [SAD_W-1:0] sad;
  logic [CNT_W:0]   sum;
  logic [CNT_W-1:0] sat;

  always_comb begin : p_chan
    logic [7:0] rl, rr, wl, wr;
    logic       opp;
    hits = '0;
    sad  = '0;
    for (int c = 0; c < 3; c++) begin
      rl  = ref_left_rgb_i[8*c +: 8];
      rr  = ref_right_rgb_i[8*c +: 8];
      wl  = win_left_rgb_i[8*c +: 8];
      wr  = win_right_rgb_i[8*c +: 8];
      // strictly opposite signs; a zero difference never counts
      opp = ((wl > rl) && (wr < rr)) || ((wl < rl) && (wr > rr));
      hits = hits + {1'b0, opp};
      sad  = sad + SAD_W'((rl > rr) ? (rl - rr) : (rr - rl));
    end
  end

  assign sum = {1'b0, count_q} + {{(CNT_W - 1){1'b0}}, hits};
  assign sat = sum[CNT_W] ? COUNT_MAX : sum[CNT_W-1:0];

  always_comb begin
    count_d = count_q;
    if (accept_i) begin
      count_d = last_i ? '0 : sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign res_o.abs_diff_sum = sad;
  assign res_o.census_total = sat;

endmodule

FILE: sv/acmc_mul.sv
// Shared 32x32 multiplier with registered 64-bit product.
// No dependencies.
module acmc_mul (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] prod_o
);

  logic [63:0] prod_d;
  logic [63:0] prod_q;

  assign prod_d = {32'b0, a_i} * {32'b0, b_i};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

FILE: sv/acmc_cost_seq.sv
// Cost sequencer: evaluates 1-exp(-x) for the AD and census terms on the
// shared multiplier and sums them. Depends on acmc_pkg and acmc_mul.
module acmc_cost_seq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  acmc_pkg::cost_ctl_t           ctl_i,
  input  acmc_pkg::win_res_t            win_i,
  input  logic [acmc_pkg::SCALE_W-1:0]  ad_scale_i,
  input  logic [acmc_pkg::SCALE_W-1:0]  census_scale_i,
  output acmc_pkg::cost_sts_t           sts_o,
  output acmc_pkg::cost_res_t           res_o
);
  import acmc_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_XMUL = 4'd1;  // x = operand * scale
  localparam logic [3:0] S_XCHK = 4'd2;  // range check, load series
  localparam logic [3:0] S_TMUL = 4'd3;  // term * t
  localparam logic [3:0] S_DMUL = 4'd4;  // n * recip(k)
  localparam logic [3:0] S_DCOR = 4'd5;  // quotient fix-up, accumulate
  localparam logic [3:0] S_SMUL = 4'd6;  // e * e
  localparam logic [3:0] S_SRND = 4'd7;  // round and rescale
  localparam logic [3:0] S_POUT = 4'd8;  // 1 - e, add to cost

  logic [3:0]         state_q, state_d;
  logic               sel_q, sel_d;      // 0: AD term, 1: census term
  logic [SAD_W-1:0]   sad_q, sad_d;
  logic [CNT_W-1:0]   tot_q, tot_d;
  logic [28:0]        t_q, t_d;
  logic [30:0]        term_q, term_d;
  logic signed [32:0] s_q, s_d;
  logic [29:0]        n_q, n_d;
  logic [3:0]         k_q, k_d;
  logic [2:0]         j_q, j_d;
  logic [30:0]        e_q, e_d;
  logic [COST_W-1:0]  acc_q, acc_d;

  logic        mul_en;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod_q;

  logic [29:0] n_now;
  logic [29:0] q0, q;
  logic [33:0] qk, r;
  logic signed [32:0] s_new;
  logic [61:0] sq_rnd;
  logic [31:0] p_full;
  logic [14:0] p_sat;
  logic [COST_W-1:0] cost_sum;
  logic        done;

  acmc_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod_q)
  );

  assign n_now = prod_q[59:30];

  // operand selection for the shared multiplier
  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state_q)
      S_XMUL: begin
        mul_en = 1'b1;
        mul_a  = sel_q ? {20'b0, tot_q} : {22'b0, sad_q};
        mul_b  = {12'b0, (sel_q ? census_scale_i : ad_scale_i)};
      end
      S_TMUL: begin
        mul_en = 1'b1;
        mul_a  = {1'b0, term_q};
        mul_b  = {3'b0, t_q};
      end
      S_DMUL: begin
        mul_en = 1'b1;
        mul_a  = {2'b0, n_now};
        mul_b  = recip_k(k_q);
      end
      S_SMUL: begin
        mul_en = 1'b1;
        mul_a  = {1'b0, e_q};
        mul_b  = {1'b0, e_q};
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  // divide-by-k fix-up: estimate is exact or one short
  assign q0    = prod_q[61:32];
  assign qk    = {4'b0, q0} * {30'b0, k_q};
  assign r     = {4'b0, n_q} - qk;
  assign q     = (r >= {30'b0, k_q}) ? (q0 + 30'd1) : q0;
  assign s_new = k_q[0] ? (s_q - $signed({3'b0, q})) : (s_q + $signed({3'b0, q}));

  assign sq_rnd = prod_q[61:0] + 62'h2000_0000;

  assign p_full   = 32'h4000_0000 - {1'b0, e_q} + 32'h0000_4000;
  assign p_sat    = (p_full[31:15] > 17'd32767) ? 15'h7FFF : p_full[29:15];
  assign cost_sum = acc_q + {1'b0, p_sat};

  always_comb begin
    state_d = state_q;
    sel_d   = sel_q;
    sad_d   = sad_q;
    tot_d   = tot_q;
    t_d     = t_q;
    term_d  = term_q;
    s_d     = s_q;
    n_d     = n_q;
    k_d     = k_q;
    j_d     = j_q;
    e_d     = e_q;
    acc_d   = acc_q;
    done    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (ctl_i.start) begin
          sad_d   = win_i.abs_diff_sum;
          tot_d   = win_i.census_total;
          sel_d   = 1'b0;
          acc_d   = '0;
          state_d = S_XMUL;
        end
      end
      S_XMUL: begin
        state_d = S_XCHK;
      end
      S_XCHK: begin
        if (prod_q[31:20] != 12'd0) begin
          // x >= 16: exp(-x) is taken as zero
          e_d     = '0;
          state_d = S_POUT;
        end else begin
          t_d     = {prod_q[19:0], 9'b0};
          term_d  = ONE_Q30;
          s_d     = $signed({2'b0, ONE_Q30});
          k_d     = 4'd1;
          state_d = S_TMUL;
        end
      end
      S_TMUL: begin
        state_d = S_DMUL;
      end
      S_DMUL: begin
        n_d     = n_now;
        state_d = S_DCOR;
      end
      S_DCOR: begin
        term_d = {1'b0, q};
        s_d    = s_new;
        if (k_q == K_LAST) begin
          if (s_new < 0) begin
            e_d = '0;
          end else if (s_new > $signed({2'b0, ONE_Q30})) begin
            e_d = ONE_Q30;
          end else begin
            e_d = s_new[30:0];
          end
          j_d     = '0;
          state_d = S_SMUL;
        end else begin
          k_d     = k_q + 4'd1;
          state_d = S_TMUL;
        end
      end
      S_SMUL: begin
        state_d = S_SRND;
      end
      S_SRND: begin
        e_d = sq_rnd[60:30];
        if (j_q == SQ_LAST) begin
          state_d = S_POUT;
        end else begin
          j_d     = j_q + 3'd1;
          state_d = S_SMUL;
        end
      end
      S_POUT: begin
        if (!sel_q) begin
          acc_d   = cost_sum;
          sel_d   = 1'b1;
          state_d = S_XMUL;
        end else if (ctl_i.out_free) begin
          done    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sel_q   <= 1'b0;
      k_q     <= '0;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
      k_q     <= k_d;
      j_q     <= j_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sad_q  <= sad_d;
    tot_q  <= tot_d;
    t_q    <= t_d;
    term_q <= term_d;
    s_q    <= s_d;
    n_q    <= n_d;
    e_q    <= e_d;
    acc_q  <= acc_d;
  end

  assign sts_o.busy = (state_q != S_IDLE);
  assign sts_o.done = done;

  assign res_o.abs_diff_sum = sad_q;
  assign res_o.census_total = tot_q;
  assign res_o.match_cost   = cost_sum;

endmodule

FILE: sv/ad_census_match_cost.sv
// AD-Census matching cost, top level: stream ports, configuration
// registers, output register. Depends on acmc_pkg, acmc_census, acmc_cost_seq.
//
//  channel   dir  handshake                   payload
//  --------  ---  --------------------------  -------------------------------------
//  s_axis    in   s_axis_tvalid/s_axis_tready  tdata 96b window pair, tlast = last
//  m_axis    out  m_axis_tvalid/m_axis_tready  tdata 40b cost, count, SAD
//  cfg       in   cfg_valid_i/cfg_ready_o      cfg_index_i, cfg_data_i (20b)
//
// Items without tlast: one per cycle if idle, counted in the census accumulator.
// An item with tlast: the cost sequencer runs both 1-exp(-x) evaluations on
//   one shared 32x32 multiplier; a term with x >= 16 skips the series, any
//   other runs 12 series steps and 5 squarings; s_axis_tready stays low
//   meanwhile, including any wait for the output register.
// Reset: async active low; scales return to 2185, census count to zero.
// The output register holds a result under back-pressure while new window
//   items are still taken.
`include "ad_census_match_cost_defines.svh"

module ad_census_match_cost (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // window items
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [23:0] ref_left_rgb, [47:24] ref_right_rgb,
  // [71:48] win_left_rgb, [95:72] win_right_rgb
  input  logic [4*acmc_pkg::PIX_W-1:0]      s_axis_tdata,
  input  logic                              s_axis_tlast,    // last_in_window
  // cost results
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [15:0] match_cost, [27:16] census_total, [37:28] abs_diff_sum, [39:38] zero
  output logic [39:0]                       m_axis_tdata,
  // configuration writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [acmc_pkg::IDX_W-1:0]        cfg_index_i,
  input  logic [acmc_pkg::SCALE_W-1:0]      cfg_data_i
);
  import acmc_pkg::*;

  logic [SCALE_W-1:0] ad_scale_q, census_scale_q;
  logic               in_acc;
  logic               cfg_wr;
  win_res_t           win_res;
  cost_ctl_t          cost_ctl;
  cost_sts_t          cost_sts;
  cost_res_t          cost_res;
  logic               out_valid_q, out_valid_d;
  cost_res_t          out_q;

  assign s_axis_tready = !cost_sts.busy;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // configuration: always ready, writes beyond the list are dropped
  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ad_scale_q     <= SCALE_RST;
      census_scale_q <= SCALE_RST;
    end else if (cfg_wr) begin
      if (cfg_index_i == REG_AD_SCALE) begin
        ad_scale_q <= cfg_data_i;
      end
      if (cfg_index_i == REG_CENSUS_SCALE) begin
        census_scale_q <= cfg_data_i;
      end
    end
  end

  acmc_census u_census (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (in_acc),
    .last_i          (s_axis_tlast),
    .ref_left_rgb_i  (s_axis_tdata[PIX_W-1:0]),
    .ref_right_rgb_i (s_axis_tdata[2*PIX_W-1:PIX_W]),
    .win_left_rgb_i  (s_axis_tdata[3*PIX_W-1:2*PIX_W]),
    .win_right_rgb_i (s_axis_tdata[4*PIX_W-1:3*PIX_W]),
    .res_o           (win_res)
  );

  // start the cost run on the window's last item; result may only land
  // when the output register is empty or being drained
  assign cost_ctl.start    = in_acc && s_axis_tlast;
  assign cost_ctl.out_free = !out_valid_q || m_axis_tready;

  acmc_cost_seq u_cost (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (cost_ctl),
    .win_i          (win_res),
    .ad_scale_i     (ad_scale_q),
    .census_scale_i (census_scale_q),
    .sts_o          (cost_sts),
    .res_o          (cost_res)
  );

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (cost_sts.done) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cost_sts.done) begin
      out_q <= cost_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_q};

  // ---- checks ----
  `ACMC_ASSERT_NEXT(a_last_blocks_input, cost_ctl.start, !s_axis_tready, "ready after last item")
  `ACMC_ASSERT_SAME(a_done_needs_room, cost_sts.done, cost_ctl.out_free, "result would overwrite")
  `ACMC_ASSERT_SAME(a_cost_in_range, m_axis_tvalid, out_q.match_cost != '1, "cost above maximum")

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for ad_census_match_cost: window items in, cost results out.
// Depends on acmc_pkg and the block's RTL. Expected costs come from a predictor kept
// inside this file.
module tb_top;
  import acmc_pkg::*;

  localparam int  CLK_HALF    = 6;
  localparam int  RST_CYCLES  = 9;
  // worst cost run plus output wait; give it room
  localparam int  SETTLE_CYC  = 120;
  localparam int  CYCLE_LIMIT = 400000;
  localparam int  MAX_REPORTS = 10;
  localparam longint unsigned Q30 = 64'd1 << 30;
  // indexes with no register behind them; writes must be ignored
  localparam logic [IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam logic [SCALE_W-1:0] SCALE_MAX = 20'hFFFFF;
  localparam logic [SCALE_W-1:0] SCALE_ONE = 20'h10000;

  typedef struct packed {
    logic [PIX_W-1:0] ref_l;
    logic [PIX_W-1:0] ref_r;
    logic [PIX_W-1:0] win_l;
    logic [PIX_W-1:0] win_r;
    logic             last;
  } win_item_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [4*PIX_W-1:0]   s_axis_tdata;
  logic                 s_axis_tlast;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [39:0]          m_axis_tdata;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [IDX_W-1:0]     cfg_index_i;
  logic [SCALE_W-1:0]   cfg_data_i;

  // predictor state: a shadow of the block's registers and census accumulator
  logic [SCALE_W-1:0]   ad_scale_m;
  logic [SCALE_W-1:0]   cen_scale_m;
  logic [CNT_W-1:0]     census_acc;
  cost_res_t            cost_expected_q[$];

  int   snd_idle_pct;
  int   rcv_idle_pct;
  int   hold_left;
  int   mismatches;
  int   results_seen;
  int   items_sent;
  int   windows_sent;
  int   cycle_cnt;

  ad_census_match_cost dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // 1 - exp(-x), x in Q16, result Q0.15 capped at 32767.
  // exp(-x/32) by a 12-term series in Q30, then squared five times.
  function automatic logic [15:0] one_minus_exp_q15(input longint unsigned x);
    longint unsigned t, term, e, p;
    longint          s;
    e = 0;
    if (x < (64'd1 << 20)) begin
      t    = x << 9;
      term = Q30;
      s    = longint'(Q30);
      for (int k = 1; k <= 12; k++) begin
        term = ((term * t) >> 30) / 64'(k);
        if (k % 2 == 1) s = s - longint'(term);
        else            s = s + longint'(term);
      end
      if (s < 0) e = 0;
      else       e = longint'(s);
      if (e > Q30) e = Q30;
      for (int n = 0; n < 5; n++)
        e = (e * e + (64'd1 << 29)) >> 30;
    end
    p = (Q30 - e + (64'd1 << 14)) >> 15;
    if (p > 64'd32767) p = 64'd32767;
    return p[15:0];
  endfunction

  // Census update for one accepted item; on the last of a window queue the cost.
  function automatic void predict_window_item(input win_item_t it);
    cost_res_t   res;
    logic [7:0]  rl, rr, wl, wr;
    int unsigned sad;
    longint unsigned x_ad, x_cen;
    sad = 0;
    for (int c = 0; c < 3; c++) begin
      rl = it.ref_l[8*c +: 8];
      rr = it.ref_r[8*c +: 8];
      wl = it.win_l[8*c +: 8];
      wr = it.win_r[8*c +: 8];
      // strictly opposite signs only; a zero difference never counts
      if (((wl > rl) && (wr < rr)) || ((wl < rl) && (wr > rr)))
        if (census_acc != COUNT_MAX) census_acc = census_acc + 1'b1;
      sad += (rl > rr) ? (rl - rr) : (rr - rl);
    end
    if (it.last) begin
      x_ad  = longint'(sad) * longint'(ad_scale_m);
      x_cen = longint'(census_acc) * longint'(cen_scale_m);
      res.abs_diff_sum = sad[SAD_W-1:0];
      res.census_total = census_acc;
      res.match_cost   = one_minus_exp_q15(x_ad) + one_minus_exp_q15(x_cen);
      cost_expected_q.push_back(res);
      windows_sent++;
      census_acc = '0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker and receiver
  // ---------------------------------------------------------------------------

  task automatic note_mismatch(input string what, input int unsigned want,
                               input int unsigned got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch on result %0d: %s expected %0d, got %0d",
               results_seen, what, want, got);
  endtask

  always @(posedge clk_i) begin
    cost_res_t want, got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[37:0];
      if (cost_expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: cost %0d count %0d sad %0d",
                   got.match_cost, got.census_total, got.abs_diff_sum);
      end else begin
        want = cost_expected_q.pop_front();
        if (got.match_cost != want.match_cost)
          note_mismatch("match_cost", want.match_cost, got.match_cost);
        if (got.census_total != want.census_total)
          note_mismatch("census_total", want.census_total, got.census_total);
        if (got.abs_diff_sum != want.abs_diff_sum)
          note_mismatch("abs_diff_sum", want.abs_diff_sum, got.abs_diff_sum);
        if (m_axis_tdata[39:38] != 2'b00)
          note_mismatch("tdata padding", 0, m_axis_tdata[39:38]);
      end
      results_seen++;
    end
  end

  // Receiver: random stalls, or a forced hold-off while hold_left is non-zero.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_cnt, cost_expected_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers; all are entered and left just after a rising edge
  // ---------------------------------------------------------------------------

  function automatic win_item_t mk_item(input logic [PIX_W-1:0] rl, rr, wl, wr,
                                        input logic last);
    win_item_t it;
    it.ref_l = rl;
    it.ref_r = rr;
    it.win_l = wl;
    it.win_r = wr;
    it.last  = last;
    return it;
  endfunction

  // Random window pixel; now and then a channel equal to the reference.
  function automatic logic [PIX_W-1:0] rand_win_px(input logic [PIX_W-1:0] ref_px);
    logic [PIX_W-1:0] px;
    px = PIX_W'($urandom);
    for (int c = 0; c < 3; c++)
      if ($urandom_range(7) == 0) px[8*c +: 8] = ref_px[8*c +: 8];
    return px;
  endfunction

  task automatic send_item(input win_item_t it);
    int gap;
    gap = 0;
    while ($urandom_range(99) < snd_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {it.win_r, it.win_l, it.ref_r, it.ref_l};
    s_axis_tlast  <= it.last;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_window_item(it);
    items_sent++;
  endtask

  task automatic release_stream();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Stream stopped; wait for every outstanding cost, then let the sequencer settle.
  task automatic wait_idle();
    while (cost_expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [SCALE_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == REG_AD_SCALE)          ad_scale_m  = val;
    else if (idx == REG_CENSUS_SCALE) cen_scale_m = val;
    @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset scales; zero window, full-range opposite windows both ways.
  task automatic test_reset_defaults();
    send_item(mk_item(24'h000000, 24'h000000, 24'h000000, 24'h000000, 1'b1));
    send_item(mk_item(24'hFFFFFF, 24'h000000, 24'h000000, 24'hFFFFFF, 1'b1));
    send_item(mk_item(24'h000000, 24'hFFFFFF, 24'hFFFFFF, 24'h000000, 1'b1));
  endtask

  // Sign rules within one window, reference pixels changing per item;
  // the last item's references give the SAD.
  task automatic test_sign_rules();
    // zero difference on the left side: no count
    send_item(mk_item(24'h404040, 24'h404040, 24'h404040, 24'h000000, 1'b0));
    // same sign on both sides: no count
    send_item(mk_item(24'h101010, 24'h101010, 24'h202020, 24'h202020, 1'b0));
    // green alone opposite
    send_item(mk_item(24'h101010, 24'h101010, 24'h102010, 24'h100010, 1'b0));
    // red and blue opposite, other references
    send_item(mk_item(24'h7F807F, 24'h80807F, 24'hFF80FF, 24'h008000, 1'b0));
    send_item(mk_item(24'h123456, 24'h654321, 24'h000000, 24'hFFFFFF, 1'b1));
    release_stream();
  endtask

  // Scale extremes, the x >= 16 cut-off, and writes to unused indexes.
  task automatic test_scale_extremes();
    wait_idle();
    write_reg(REG_AD_SCALE, '0);
    write_reg(REG_CENSUS_SCALE, SCALE_MAX);
    send_item(mk_item(24'hFFFFFF, 24'h000000, 24'h000000, 24'hFFFFFF, 1'b1));
    send_item(mk_item(24'h000000, 24'h000000, 24'h000000, 24'h000000, 1'b1));
    release_stream();
    wait_idle();
    write_reg(REG_AD_SCALE, SCALE_MAX);
    write_reg(REG_CENSUS_SCALE, '0);
    // SAD 1: just under the cut-off; SAD 2: over it
    send_item(mk_item(24'h000001, 24'h000000, 24'h000002, 24'h000000, 1'b1));
    send_item(mk_item(24'h000002, 24'h000000, 24'h000000, 24'h000000, 1'b1));
    send_item(mk_item(24'hFFFFFF, 24'h000000, 24'h000000, 24'hFFFFFF, 1'b1));
    release_stream();
    wait_idle();
    write_reg(REG_AD_SCALE, SCALE_ONE);
    write_reg(REG_CENSUS_SCALE, SCALE_ONE);
    write_reg(REG_SPARE_A, SCALE_MAX);
    write_reg(REG_SPARE_B, '0);
    send_item(mk_item(24'h010203, 24'h030201, 24'h020000, 24'h000000, 1'b1));
    send_item(mk_item(24'h0F0F0F, 24'h000000, 24'h000000, 24'h010101, 1'b1));
    release_stream();
    wait_idle();
    write_reg(REG_AD_SCALE, SCALE_RST);
    write_reg(REG_CENSUS_SCALE, SCALE_RST);
  endtask

  // One long window with every channel opposite, for a large census count.
  task automatic test_long_window();
    logic [PIX_W-1:0] rl, rr, wl, wr;
    logic [7:0]       l, r;
    wait_idle();
    write_reg(REG_CENSUS_SCALE, 20'd16);
    for (int n = 0; n < 100; n++) begin
      for (int c = 0; c < 3; c++) begin
        l = 8'($urandom_range(1, 254));
        r = 8'($urandom_range(1, 254));
        rl[8*c +: 8] = l;
        rr[8*c +: 8] = r;
        if ($urandom_range(1)) begin
          wl[8*c +: 8] = 8'($urandom_range(l + 1, 255));
          wr[8*c +: 8] = 8'($urandom_range(0, r - 1));
        end else begin
          wl[8*c +: 8] = 8'($urandom_range(0, l - 1));
          wr[8*c +: 8] = 8'($urandom_range(r + 1, 255));
        end
      end
      send_item(mk_item(rl, rr, wl, wr, n == 99));
    end
    release_stream();
  endtask

  // Random windows: mostly well-formed (fixed references, short lengths), with
  // some reference changes mid-window and some over-long windows.
  task automatic test_random_windows(input int n_items);
    logic [PIX_W-1:0] rl, rr;
    int sent, len, pick;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 60)      len = $urandom_range(1, 8);
      else if (pick < 85) len = $urandom_range(9, 30);
      else if (pick < 97) len = $urandom_range(31, 81);
      else                len = $urandom_range(82, 120);
      rl = PIX_W'($urandom);
      rr = PIX_W'($urandom);
      for (int n = 0; n < len; n++) begin
        if ($urandom_range(9) == 0) begin
          rl = PIX_W'($urandom);
          rr = PIX_W'($urandom);
        end
        send_item(mk_item(rl, rr, rand_win_px(rl), rand_win_px(rr), n == len - 1));
        sent++;
      end
    end
    release_stream();
  endtask

  // Receiver stops for a long stretch while items keep coming, so the output
  // register and the sequencer fill and the input stalls; then drain.
  task automatic test_receiver_hold();
    logic [PIX_W-1:0] rl, rr;
    hold_left = 600;
    for (int n = 0; n < 40; n++) begin
      rl = PIX_W'($urandom);
      rr = PIX_W'($urandom);
      send_item(mk_item(rl, rr, rand_win_px(rl), rand_win_px(rr), (n % 3) != 1));
    end
    release_stream();
    wait_idle();
  endtask

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    ad_scale_m    = SCALE_RST;
    cen_scale_m   = SCALE_RST;
    census_acc    = '0;
    snd_idle_pct  = 0;
    rcv_idle_pct  = 0;
    hold_left     = 0;
    mismatches    = 0;
    results_seen  = 0;
    items_sent    = 0;
    windows_sent  = 0;
    cycle_cnt     = 0;

    repeat (RST_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    snd_idle_pct = 7;
    rcv_idle_pct = 74;
    test_reset_defaults();
    test_sign_rules();
    test_scale_extremes();
    test_long_window();

    wait_idle();
    write_reg(REG_AD_SCALE, SCALE_W'($urandom_range(0, 65535)));
    write_reg(REG_CENSUS_SCALE, SCALE_W'($urandom_range(0, 65535)));
    test_random_windows(110);

    wait_idle();
    snd_idle_pct = 74;
    rcv_idle_pct = 7;
    write_reg(REG_AD_SCALE, SCALE_W'($urandom));
    write_reg(REG_CENSUS_SCALE, SCALE_W'($urandom_range(0, 8192)));
    test_random_windows(110);
    test_receiver_hold();

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    write_reg(REG_AD_SCALE, SCALE_RST);
    write_reg(REG_CENSUS_SCALE, SCALE_W'($urandom_range(0, 32768)));
    test_random_windows(110);

    wait_idle();
    $display("covered %0d items in %0d windows, %0d results checked",
             items_sent, windows_sent, results_seen);
    $display("scale extremes, cut-off, spare indexes, long window, receiver hold included");
    if (mismatches == 0 && cost_expected_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, cost_expected_q.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+sv
sv/acmc_pkg.sv
sv/acmc_census.sv
sv/acmc_mul.sv
sv/acmc_cost_seq.sv
sv/ad_census_match_cost.sv
tb/sv/tb_top.sv
